// File: hdl/glzw_pkg.sv
// Package for the GIF LZW decoder: status codes, modes, finish states, CSR indices.
// No dependencies.
`default_nettype none
package glzw_pkg;
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_PUSH  = 2'd1;
   localparam logic [1:0] MODE_PULL  = 2'd2;

   localparam logic [2:0] ST_PIXEL   = 3'd0;
   localparam logic [2:0] ST_AGAIN   = 3'd1;
   localparam logic [2:0] ST_NEED    = 3'd2;
   localparam logic [2:0] ST_TAKEN   = 3'd3;
   localparam logic [2:0] ST_REFUSED = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;
   localparam logic [2:0] ST_ERROR   = 3'd6;
   localparam logic [2:0] ST_STARTED = 3'd7;

   localparam logic [1:0] FIN_RUN  = 2'd0;
   localparam logic [1:0] FIN_DONE = 2'd1;
   localparam logic [1:0] FIN_FAIL = 2'd2;

   localparam logic CSR_MIN_CODE = 1'b0;
   localparam logic CSR_PIX_CNT  = 1'b1;
endpackage
`default_nettype wire

// File: hdl/glzw_dict.sv
// Dictionary memory for the GIF LZW decoder: prefix, suffix, first character.
// One write port, one read port, registered read data. Uses glzw_pkg.
`default_nettype none
module glzw_dict #(
   parameter int ENTRIES = 4096,
   parameter int AW = 12
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [AW-1:0] wr_prefix,
   input  wire logic [7:0]    wr_suffix,
   input  wire logic [7:0]    wr_first,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [AW-1:0] rd_prefix,
   output logic      [7:0]    rd_suffix,
   output logic      [7:0]    rd_first
);
   import glzw_pkg::*;
   logic [AW-1:0] prefix_mem [ENTRIES];
   logic [7:0]    suffix_mem [ENTRIES];
   logic [7:0]    first_mem  [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prefix_mem[wr_addr] <= wr_prefix;
         suffix_mem[wr_addr] <= wr_suffix;
         first_mem[wr_addr]  <= wr_first;
      end
      rd_prefix <= prefix_mem[rd_addr];
      rd_suffix <= suffix_mem[rd_addr];
      rd_first  <= first_mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: hdl/glzw_stack.sv
// String stack memory for the GIF LZW decoder.
// One write port, one read port, registered read data. Uses glzw_pkg.
`default_nettype none
module glzw_stack #(
   parameter int ENTRIES = 4096,
   parameter int AW = 12
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);
   import glzw_pkg::*;
   logic [7:0] mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: hdl/gif_lzw_decoder_core.sv
// GIF LZW decoder top level: bit buffer, code handling, chain walk, output register.
// One request at a time; req_stall holds while busy or an answer waits.
// Pixel pop: S_POP (stack read), S_OUT. New code: S_FC, S_WALK per link, S_POP, S_OUT.
// Synchronous active-high reset: control cleared, min_code_size 8, pixel_count 64000.
// Uses glzw_pkg, glzw_dict, glzw_stack.
`default_nettype none
module gif_lzw_decoder_core #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int MAX_CODE_BITS = 12
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_mode,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_pixel,
   output logic [2:0]      rsp_status,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [15:0] csr_data
);
   import glzw_pkg::*;
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int DW = AW + 1;
   localparam logic [DW-1:0] TE = DW'(TABLE_ENTRIES);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POP  = 3'd1;
   localparam logic [2:0] S_FC   = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [3:0]    min_ff, min_in;
   logic [15:0]   count_ff, count_in;
   logic [8:0]    clear_ff, clear_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [DW-1:0] nfc_ff, nfc_in;
   logic [3:0]    width_ff, width_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic          fac_ff, fac_in;
   logic [23:0]   hold_ff, hold_in;
   logic [4:0]    held_ff, held_in;
   logic [15:0]   emitted_ff, emitted_in;
   logic [1:0]    fin_ff, fin_in;
   logic [AW-1:0] code_ff, code_in;
   logic [AW-1:0] walk_ff, walk_in;
   logic          kwk_ff, kwk_in;
   logic [7:0]    kwch_ff, kwch_in;
   logic [7:0]    pfc_ff, pfc_in;
   logic          ovalid_ff, ovalid_in;
   logic [7:0]    opix_ff, opix_in;
   logic [2:0]    ostat_ff, ostat_in;

   logic          d_we, s_we;
   logic [AW-1:0] d_waddr, d_wpre, d_raddr, d_rpre;
   logic [7:0]    d_wsuf, d_wfirst, d_rsuf, d_rfirst;
   logic [AW-1:0] s_waddr, s_raddr;
   logic [7:0]    s_wdata, s_rdata;

   glzw_dict #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_dict (
      .clock, .wr_en(d_we), .wr_addr(d_waddr), .wr_prefix(d_wpre),
      .wr_suffix(d_wsuf), .wr_first(d_wfirst), .rd_addr(d_raddr),
      .rd_prefix(d_rpre), .rd_suffix(d_rsuf), .rd_first(d_rfirst));
   glzw_stack #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_stack (
      .clock, .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata));

   assign req_stall  = (state_ff != S_IDLE) || ovalid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = ovalid_ff;
   assign rsp_pixel  = opix_ff;
   assign rsp_status = ostat_ff;

   function automatic logic [3:0] init_width(input logic [3:0] m);
      return m + 4'd1;
   endfunction

   function automatic logic [3:0] msat_of(input logic [8:0] c);
      logic [3:0] r;
      r = 4'd2;
      for (int i = 2; i <= 8; i++) if (c[i]) r = 4'(i);
      return r;
   endfunction

   logic [3:0]    msat;
   logic [AW-1:0] mask, code_x;
   logic [DW-1:0] code_d, clr_d;
   logic          take;
   logic [DW-1:0] nfc_p1;
   logic [7:0]    fc_code;

   always_comb begin
      msat = (min_ff < 4'd2) ? 4'd2 : ((min_ff > 4'd8) ? 4'd8 : min_ff);
      mask = AW'((DW'(1) << width_ff) - DW'(1));
      code_x = hold_ff[AW-1:0] & mask;
      code_d = DW'(code_ff);
      clr_d  = DW'(clear_ff);
      nfc_p1 = nfc_ff + DW'(1);
      fc_code = (code_d < clr_d) ? code_ff[7:0] : d_rfirst;
      take = req_valid && !req_stall;

      state_in = state_ff; min_in = min_ff; count_in = count_ff; clear_in = clear_ff;
      depth_in = depth_ff; nfc_in = nfc_ff; width_in = width_ff; prev_in = prev_ff;
      fac_in = fac_ff; hold_in = hold_ff; held_in = held_ff;
      emitted_in = emitted_ff; fin_in = fin_ff; code_in = code_ff; walk_in = walk_ff;
      kwk_in = kwk_ff; kwch_in = kwch_ff; pfc_in = pfc_ff;
      ovalid_in = ovalid_ff; opix_in = opix_ff; ostat_in = ostat_ff;
      d_we = 1'b0; d_waddr = nfc_ff[AW-1:0]; d_wpre = prev_ff;
      d_wsuf = 8'd0; d_wfirst = 8'd0; d_raddr = walk_ff;
      s_we = 1'b0; s_waddr = depth_ff[AW-1:0]; s_wdata = 8'd0;
      s_raddr = AW'(depth_ff - DW'(1));

      if (ovalid_ff && !rsp_stall) ovalid_in = 1'b0;
      if (csr_valid) begin
         if (csr_index == CSR_MIN_CODE) min_in = csr_data[3:0];
         else count_in = csr_data;
      end

      case (state_ff)
         S_IDLE: if (take) begin
            opix_in = 8'd0;
            case (req_mode)
               MODE_START: begin
                  clear_in = 9'(9'd1 << msat);
                  nfc_in = DW'(9'(9'd1 << msat)) + DW'(2);
                  width_in = init_width(msat);
                  fac_in = 1'b1; depth_in = '0; prev_in = '0; hold_in = '0;
                  held_in = '0; emitted_in = '0; fin_in = FIN_RUN;
                  ostat_in = ST_STARTED; ovalid_in = 1'b1;
               end
               MODE_PUSH: begin
                  if (held_ff >= 5'd16) ostat_in = ST_REFUSED;
                  else begin
                     hold_in = hold_ff | (24'(req_data_byte) << held_ff);
                     held_in = held_ff + 5'd8;
                     ostat_in = ST_TAKEN;
                  end
                  ovalid_in = 1'b1;
               end
               MODE_PULL: begin
                  ovalid_in = 1'b1;
                  if (fin_ff == FIN_DONE) ostat_in = ST_DONE;
                  else if (fin_ff == FIN_FAIL) ostat_in = ST_ERROR;
                  else if (emitted_ff == count_ff) begin
                     if (depth_ff != '0) begin
                        fin_in = FIN_FAIL; ostat_in = ST_ERROR;
                     end else begin
                        fin_in = FIN_DONE; ostat_in = ST_DONE;
                     end
                  end else if (depth_ff != '0) begin
                     ovalid_in = 1'b0; state_in = S_POP;
                  end else if (held_ff < {1'b0, width_ff}) ostat_in = ST_NEED;
                  else begin
                     hold_in = hold_ff >> width_ff;
                     held_in = held_ff - {1'b0, width_ff};
                     code_in = code_x;
                     if (DW'(code_x) == clr_d) begin
                        nfc_in = clr_d + DW'(2);
                        width_in = init_width(msat_of(clear_ff));
                        fac_in = 1'b1; ostat_in = ST_AGAIN;
                     end else if (DW'(code_x) == clr_d + DW'(1)) begin
                        fin_in = FIN_FAIL; ostat_in = ST_ERROR;
                     end else if (fac_ff) begin
                        if (DW'(code_x) >= clr_d) begin
                           fin_in = FIN_FAIL; ostat_in = ST_ERROR;
                        end else begin
                           fac_in = 1'b0; prev_in = code_x; pfc_in = code_x[7:0];
                           s_we = 1'b1; s_waddr = '0; s_wdata = code_x[7:0];
                           depth_in = DW'(1);
                           ovalid_in = 1'b0; state_in = S_POP;
                        end
                     end else if (DW'(code_x) < nfc_ff ||
                                  (DW'(code_x) == nfc_ff && nfc_ff < TE)) begin
                        kwk_in = (DW'(code_x) == nfc_ff);
                        d_raddr = kwk_in ? prev_ff : code_x;
                        ovalid_in = 1'b0; state_in = S_FC;
                     end else begin
                        fin_in = FIN_FAIL; ostat_in = ST_ERROR;
                     end
                  end
               end
               default: begin
                  ostat_in = ST_ERROR; ovalid_in = 1'b1;
               end
            endcase
         end
         S_POP: begin
            s_raddr = AW'(depth_ff - DW'(1));
            depth_in = depth_ff - DW'(1);
            state_in = S_OUT;
         end
         S_OUT: begin
            opix_in = s_rdata; ostat_in = ST_PIXEL; ovalid_in = 1'b1;
            emitted_in = emitted_ff + 16'd1;
            state_in = S_IDLE;
         end
         S_FC: begin
            // first char of the looked-up code (prev for KwKwK) is ready
            kwch_in = kwk_ff ? ((DW'(prev_ff) < clr_d) ? prev_ff[7:0] : d_rfirst)
                             : fc_code;
            pfc_in = kwch_in;
            if (nfc_ff < TE) begin
               d_we = 1'b1; d_wpre = prev_ff;
               d_wsuf = kwch_in;
               d_wfirst = pfc_ff;
               nfc_in = nfc_p1;
               if (nfc_p1 > (DW'(1) << width_ff) - DW'(1) &&
                   width_ff < 4'(MAX_CODE_BITS))
                  width_in = width_ff + 4'd1;
            end
            prev_in = code_ff;
            if (kwk_ff) begin
               // new entry: push its suffix here, walk on from its prefix
               s_we = 1'b1; s_waddr = '0; s_wdata = kwch_in;
               depth_in = DW'(1);
               walk_in = prev_ff;
               d_raddr = prev_ff;
            end else begin
               depth_in = '0;
               walk_in = code_ff;
               d_raddr = code_ff;
            end
            state_in = S_WALK;
         end
         S_WALK: begin
            if (DW'(walk_ff) >= clr_d + DW'(2)) begin
               if (depth_ff < TE) begin
                  s_we = 1'b1; s_wdata = d_rsuf; depth_in = depth_ff + DW'(1);
               end
               walk_in = d_rpre; d_raddr = d_rpre;
               if (depth_ff >= TE) state_in = S_POP;
            end else begin
               if (DW'(walk_ff) < clr_d && depth_ff < TE) begin
                  s_we = 1'b1; s_wdata = walk_ff[7:0]; depth_in = depth_ff + DW'(1);
               end
               state_in = S_POP;
               if (depth_ff == '0 && DW'(walk_ff) >= clr_d) begin
                  fin_in = FIN_FAIL; ostat_in = ST_ERROR; opix_in = 8'd0;
                  ovalid_in = 1'b1; state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; min_ff <= 4'd8; count_ff <= 16'd64000;
         clear_ff <= 9'd256; nfc_ff <= DW'(258); width_ff <= 4'd9;
         depth_ff <= '0; prev_ff <= '0; fac_ff <= 1'b1; hold_ff <= '0;
         held_ff <= '0; emitted_ff <= '0; fin_ff <= FIN_RUN;
         ovalid_ff <= 1'b0; kwk_ff <= 1'b0;
      end else begin
         state_ff <= state_in; min_ff <= min_in; count_ff <= count_in;
         clear_ff <= clear_in; nfc_ff <= nfc_in; width_ff <= width_in;
         depth_ff <= depth_in; prev_ff <= prev_in; fac_ff <= fac_in;
         hold_ff <= hold_in; held_ff <= held_in; emitted_ff <= emitted_in;
         fin_ff <= fin_in; ovalid_ff <= ovalid_in; kwk_ff <= kwk_in;
      end
      code_ff <= code_in; walk_ff <= walk_in; kwch_ff <= kwch_in; pfc_ff <= pfc_in;
      opix_ff <= opix_in; ostat_ff <= ostat_in;
   end
endmodule
`default_nettype wire
